>>> rtl/d2i_pkg.sv
// ----------------------------------------------------------------------------
// d2i_pkg
// Target codes and constants shared by the double-to-integer converter.
// ----------------------------------------------------------------------------
package d2i_pkg;

  typedef enum logic [3:0] {
    TGT_BOOL  = 4'd0,
    TGT_BYTE  = 4'd1,
    TGT_DINT  = 4'd2,
    TGT_DWORD = 4'd3,
    TGT_INT   = 4'd4,
    TGT_LINT  = 4'd5,
    TGT_REAL  = 4'd6,
    TGT_SINT  = 4'd7,
    TGT_UDINT = 4'd8,
    TGT_UINT  = 4'd9,
    TGT_USINT = 4'd10,
    TGT_WORD  = 4'd11
  } tgt_e;

  localparam logic [63:0] BIT63       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DINT_MIN    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] QNAN32      = 64'h0000_0000_7FC0_0000;
  localparam logic [62:0] FLTMAX_DBL  = 63'h47EF_FFFF_E000_0000;

  // Operand captured at the input register
  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] value_bits;
  } op_t;

  // Converted beat
  typedef struct packed {
    logic [63:0] result_bits;
    logic        valid_res;
  } res_t;

endpackage

>>> rtl/d2i_int_conv.sv
// ----------------------------------------------------------------------------
// d2i_int_conv
// Rounds a double half away from zero and fits it to an integer target.
// ----------------------------------------------------------------------------
module d2i_int_conv (
  input  d2i_pkg::op_t  op_i,
  output d2i_pkg::res_t res_o
);
  import d2i_pkg::*;

  logic        neg;
  logic [10:0] e;
  logic [51:0] frac;
  logic [52:0] mant;
  logic [63:0] m;
  logic        over;
  logic [5:0]  sh;
  logic [6:0]  w;
  logic        sgn_t;
  logic        in_rng;
  logic [64:0] lim;
  logic [63:0] mag, msk;

  always_comb begin
    neg  = op_i.value_bits[63];
    e    = op_i.value_bits[62:52];
    frac = op_i.value_bits[51:0];
    mant = {1'b1, frac};
    m    = '0;
    over = 1'b0;
    sh   = '0;
    if (e == 11'd1022) begin
      m = 64'd1;
    end else if (e >= 11'd1023 && e <= 11'd1075) begin
      sh = 6'(11'd1075 - e);
      m  = 64'(mant >> sh);
      if (sh != 6'd0) m = m + 64'((mant >> (sh - 6'd1)) & 53'd1);
    end else if (e > 11'd1075 && e < 11'd1086) begin
      m = {11'd0, mant} << 6'(e - 11'd1075);
    end else if (e >= 11'd1086) begin
      m    = BIT63;
      over = !(e == 11'd1086 && frac == '0);
    end

    case (op_i.cmd)
      TGT_BYTE, TGT_USINT: begin w = 7'd8;  sgn_t = 1'b0; end
      TGT_SINT:            begin w = 7'd8;  sgn_t = 1'b1; end
      TGT_INT:             begin w = 7'd16; sgn_t = 1'b1; end
      TGT_UINT, TGT_WORD:  begin w = 7'd16; sgn_t = 1'b0; end
      TGT_DINT:            begin w = 7'd32; sgn_t = 1'b1; end
      TGT_LINT:            begin w = 7'd64; sgn_t = 1'b1; end
      default:             begin w = 7'd32; sgn_t = 1'b0; end
    endcase

    if (sgn_t) begin
      lim    = 65'd1 << (w - 7'd1);
      in_rng = neg ? ({1'b0, m} <= lim) : ({1'b0, m} < lim);
    end else begin
      lim    = (65'd1 << w) - 65'd1;
      in_rng = ({1'b0, m} <= lim) && (!neg || m == '0);
    end
    msk = 64'((65'd1 << w) - 65'd1);
    mag = neg ? (64'd0 - m) : m;

    res_o.valid_res = in_rng && !over;
    if (m[63]) begin
      if (op_i.cmd == TGT_LINT)      res_o.result_bits = BIT63;
      else if (op_i.cmd == TGT_DINT) res_o.result_bits = DINT_MIN;
      else                           res_o.result_bits = '0;
    end else begin
      res_o.result_bits = mag & msk;
    end
  end

endmodule

>>> rtl/d2i_real_conv.sv
// ----------------------------------------------------------------------------
// d2i_real_conv
// Rounds a double to single precision, nearest-even, with subnormals.
// ----------------------------------------------------------------------------
module d2i_real_conv (
  input  logic [63:0]   x_i,
  output d2i_pkg::res_t res_o
);
  import d2i_pkg::*;

  logic [10:0] e;
  logic [63:0] mant;
  logic [5:0]  sh;
  logic [63:0] q, rem, half;
  logic        up;
  logic [24:0] qn;
  logic [7:0]  fe;
  logic [31:0] r;

  always_comb begin
    e    = x_i[62:52];
    mant = {11'd0, 1'b1, x_i[51:0]};
    // normal range: shift 29, subnormal: shift 1023-97-e... i.e. 926 - e
    if (e >= 11'd897) sh = 6'd29;
    else if (e <= 11'd866) sh = 6'd60;
    else sh = 6'(11'd926 - e);
    q    = mant >> sh;
    half = 64'd1 << (sh - 6'd1);
    rem  = mant & ((64'd1 << sh) - 64'd1);
    up   = (rem > half) || (rem == half && q[0]);
    qn   = 25'(q) + 25'(up);
    fe   = 8'(e - 11'd896);
    r    = '0;
    if (e == 11'd0 || e <= 11'd866) begin
      r = {x_i[63], 31'd0};
    end else if (e >= 11'd897) begin
      if (qn[24]) r = {x_i[63], 8'(fe + 8'd1), 23'd0};
      else        r = {x_i[63], fe, qn[22:0]};
    end else begin
      r = {x_i[63], 31'(qn)};
    end
    if (e == 11'h7FF || x_i[62:0] > FLTMAX_DBL) begin
      res_o.result_bits = QNAN32;
      res_o.valid_res   = 1'b0;
    end else begin
      res_o.result_bits = {32'd0, r};
      res_o.valid_res   = 1'b1;
    end
  end

endmodule

>>> rtl/double_to_integer_converter.sv
// ----------------------------------------------------------------------------
// double_to_integer_converter
// Converts one binary64 operand to the selected integer, BOOL or REAL type.
// ----------------------------------------------------------------------------
// channel   ports                               handshake
// command   cmd_i, value_bits_i                 start high, busy low
// result    result_bits_o, valid_res_o          done_o high for one cycle
//
// Input register, then result register: done_o is registered alongside the
// result register and is high while the beat is on the result ports. busy is
// held low, so a command is taken every cycle. Reset clears the two valid flags;
// payload registers are not reset. The receiver cannot stall, so nothing
// backs up.
module double_to_integer_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  cmd_i,
  input  logic [63:0] value_bits_i,
  output logic        done_o,
  output logic [63:0] result_bits_o,
  output logic        valid_res_o
);
  import d2i_pkg::*;

  op_t  op_q;
  logic op_vld_q, done_q;
  res_t int_res, real_res, res_d, res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      op_vld_q <= start && !busy;
      done_q   <= op_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) op_q <= '{cmd: cmd_i, value_bits: value_bits_i};
    if (op_vld_q) res_q <= res_d;
  end

  d2i_int_conv u_int (.op_i(op_q), .res_o(int_res));
  d2i_real_conv u_real (.x_i(op_q.value_bits), .res_o(real_res));

  // special cases: undefined code, REAL, non-finite, BOOL
  always_comb begin
    res_d = int_res;
    if (op_q.cmd > TGT_WORD) begin
      res_d = '0;
    end else if (op_q.cmd == TGT_REAL) begin
      res_d = real_res;
    end else if (op_q.value_bits[62:52] == 11'h7FF) begin
      res_d = '0;
      if (op_q.cmd == TGT_BOOL)      res_d.result_bits = 64'd1;
      else if (op_q.cmd == TGT_DINT) res_d.result_bits = DINT_MIN;
      else if (op_q.cmd == TGT_LINT) res_d.result_bits = BIT63;
    end else if (op_q.cmd == TGT_BOOL) begin
      res_d.result_bits = {63'd0, |op_q.value_bits[62:0]};
      res_d.valid_res   = 1'b1;
    end
  end

  assign done_o        = done_q;
  assign result_bits_o = res_q.result_bits;
  assign valid_res_o   = res_q.valid_res;

endmodule

>>> rtl/d2i_checker.sv
// ----------------------------------------------------------------------------
// d2i_sva
// Port-level assertions for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module d2i_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [3:0]  cmd_i,
  input logic        done_o,
  input logic [63:0] result_bits_o,
  input logic        valid_res_o
);
  import d2i_pkg::*;

  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o) else $error("missing result beat");
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2)) else $error("spurious result beat");
  a_bad_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i > TGT_WORD) |-> ##2 (result_bits_o == '0 && !valid_res_o))
    else $error("undefined code not zeroed");
  a_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i != TGT_LINT && cmd_i <= TGT_WORD)
      |-> ##2 (result_bits_o[63:32] == '0)) else $error("upper bits not zero");

endmodule

bind double_to_integer_converter d2i_sva u_d2i_sva (.*);
